// ----- hw/rtl/rcm_pkg.sv -----
package rcm_pkg;

	typedef enum logic [2:0] {
		OP_CLEAR    = 3'd0,
		OP_ADD      = 3'd1,
		OP_REMOVE   = 3'd2,
		OP_COST     = 3'd3,
		OP_SNAPSHOT = 3'd4,
		OP_HISTORY  = 3'd5,
		OP_QUERY    = 3'd6,
		OP_OVERFLOW = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		REG_COLUMNS  = 3'd0,
		REG_ROWS     = 3'd1,
		REG_HCAP     = 3'd2,
		REG_VCAP     = 3'd3,
		REG_CWEIGHT  = 3'd4,
		REG_HWEIGHT  = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DIV,
		ST_COST,
		ST_SWEEP_RD,
		ST_SWEEP_WAIT,
		ST_SWEEP_WR,
		ST_DONE
	} state_t;

	localparam int unsigned COST_W   = 40;
	localparam int unsigned SUM_W    = 21;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam int unsigned USE_W    = 8;
	localparam int unsigned HIST_W   = 16;
	localparam int unsigned WT_W     = 16;
	localparam int unsigned NUM_W    = WT_W + USE_W + 1;
	localparam int unsigned CAP_W    = 8;
	localparam int unsigned ZERO_CAP_SCALE = 10;

	// divider handshake between sequencer and shared divider
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

// ----- hw/rtl/routing_congestion_map.sv -----
// Congestion cost map for a routing grid. Each transaction carries an operation and one grid
// step. One result comes back per transaction, and the input stalls until that result has been
// taken. Add, remove and query pass through the read, execute and done states, and a bad step
// goes straight to done. Cost runs a bit-serial divider over the 25-bit numerator, or skips it
// when the capacity is zero. Snapshot, history update and overflow sum sweep every memory
// address, each one through the sweep read, wait and write states. Clear writes one address per
// cycle. A stalled result holds the done state until it is taken. After reset a clearing pass
// over every address runs before the first transaction is taken. Write configuration registers
// only while no transaction is in flight.
module routing_congestion_map #(
	parameter int unsigned MAX_COLUMNS = 64,
	parameter int unsigned MAX_ROWS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [5:0]  from_x,
	input  logic [5:0]  from_y,
	input  logic [5:0]  to_x,
	input  logic [5:0]  to_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [39:0] step_cost,
	output logic        edge_marked,
	output logic [20:0] overflow_sum,
	output logic        bad_step
);

	localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned XW    = $clog2(MAX_COLUMNS);
	localparam int unsigned YW    = $clog2(MAX_ROWS);
	localparam int unsigned XYW   = XW > YW ? XW : YW;
	localparam int unsigned CW    = (XYW > 7 ? XYW : 7) + 1;
	localparam int unsigned USE_W = rcm_pkg::USE_W;
	localparam int unsigned HIST_W = rcm_pkg::HIST_W;
	localparam int unsigned NUM_W = rcm_pkg::NUM_W;

	// configuration registers
	logic [6:0]  cols_q, rows_q;
	logic [7:0]  hcap_q, vcap_q;
	logic [15:0] cwt_q, hwt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 7'd64;
			rows_q <= 7'd64;
			hcap_q <= 8'd1;
			vcap_q <= 8'd1;
			cwt_q  <= 16'd256;
			hwt_q  <= 16'd256;
		end else if (cfg_we) begin
			unique case (rcm_pkg::reg_idx_t'(cfg_index))
				rcm_pkg::REG_COLUMNS: cols_q <= cfg_data[6:0];
				rcm_pkg::REG_ROWS:    rows_q <= cfg_data[6:0];
				rcm_pkg::REG_HCAP:    hcap_q <= cfg_data[7:0];
				rcm_pkg::REG_VCAP:    vcap_q <= cfg_data[7:0];
				rcm_pkg::REG_CWEIGHT: cwt_q  <= cfg_data;
				rcm_pkg::REG_HWEIGHT: hwt_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// grid size clamped to the parameters
	logic [CW-1:0] cols_u, rows_u;
	always_comb begin
		cols_u = (CW'(cols_q) > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(cols_q);
		rows_u = (CW'(rows_q) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(rows_q);
	end

	// step decode
	logic       step_ok, step_h;
	logic [5:0] sx, sy;
	always_comb begin
		logic in_grid;
		in_grid = CW'(from_x) < cols_u && CW'(to_x) < cols_u
			&& CW'(from_y) < rows_u && CW'(to_y) < rows_u;
		step_h = 1'b0;
		sx = from_x;
		sy = from_y;
		step_ok = 1'b0;
		if (from_y == to_y && (7'(from_x) + 7'd1 == 7'(to_x)
				|| 7'(to_x) + 7'd1 == 7'(from_x))) begin
			step_h = 1'b1;
			step_ok = in_grid;
			sx = from_x < to_x ? from_x : to_x;
		end else if (from_x == to_x && (7'(from_y) + 7'd1 == 7'(to_y)
				|| 7'(to_y) + 7'd1 == 7'(from_y))) begin
			step_ok = in_grid;
			sy = from_y < to_y ? from_y : to_y;
		end
	end

	rcm_pkg::state_t state_q, state_d;
	rcm_pkg::op_t    op_q;
	logic            horiz_q;
	logic            clear_q;
	logic [AW-1:0]   addr_q;
	logic [XW-1:0]   ax_q;
	logic [YW-1:0]   ay_q;
	logic [39:0]     cost_q;
	logic            mark_q;
	logic [20:0]     sum_q;
	logic            bad_q;
	logic [NUM_W-1:0] num_q;
	logic [39:0]     hprod_q;

	// memory ports
	logic              h_we, v_we;
	logic [USE_W-1:0]  h_use, v_use, h_wuse, v_wuse;
	logic [HIST_W-1:0] h_hist, v_hist, h_whist, v_whist;
	logic              h_mark, v_mark, h_wmark, v_wmark;
	logic [AW-1:0]     raddr;

	rcm_edge_store #(.DEPTH(DEPTH)) u_hstore (
		.clk(clk), .we(h_we), .waddr(addr_q), .wuse(h_wuse), .whist(h_whist),
		.wmark(h_wmark), .raddr(raddr), .ruse(h_use), .rhist(h_hist), .rmark(h_mark)
	);

	rcm_edge_store #(.DEPTH(DEPTH)) u_vstore (
		.clk(clk), .we(v_we), .waddr(addr_q), .wuse(v_wuse), .whist(v_whist),
		.wmark(v_wmark), .raddr(raddr), .ruse(v_use), .rhist(v_hist), .rmark(v_mark)
	);

	// shared divider
	rcm_pkg::div_ctl_t  div_ctl;
	logic               div_start;
	logic [NUM_W-1:0]   div_quo;
	logic [7:0]         cap_sel;

	assign cap_sel = horiz_q ? hcap_q : vcap_q;

	rcm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(num_q),
		.divisor(cap_sel), .ctl(div_ctl), .quotient(div_quo)
	);

	// edge in grid at sweep position
	logic hin, vin;
	always_comb begin
		hin = CW'(ay_q) < rows_u && CW'(ax_q) + CW'(1) < cols_u;
		vin = CW'(ax_q) < cols_u && CW'(ay_q) + CW'(1) < rows_u;
	end

	logic last_addr;
	assign last_addr = addr_q == AW'(DEPTH - 1);

	// sequencer next state and memory writes
	always_comb begin
		logic [USE_W-1:0] cur;
		logic [USE_W-1:0] nxt;
		state_d = state_q;
		h_we = 1'b0;
		v_we = 1'b0;
		h_wuse = h_use;
		v_wuse = v_use;
		h_whist = h_hist;
		v_whist = v_hist;
		h_wmark = h_mark;
		v_wmark = v_mark;
		div_start = 1'b0;
		raddr = addr_q;
		cur = horiz_q ? h_use : v_use;
		nxt = cur;
		unique case (state_q)
			rcm_pkg::ST_INIT: begin
				h_we = 1'b1;
				v_we = 1'b1;
				h_wuse = '0; v_wuse = '0;
				h_whist = '0; v_whist = '0;
				h_wmark = 1'b0; v_wmark = 1'b0;
				if (last_addr) state_d = clear_q ? rcm_pkg::ST_DONE : rcm_pkg::ST_IDLE;
			end
			rcm_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (rcm_pkg::op_t'(operation))
						rcm_pkg::OP_CLEAR: state_d = rcm_pkg::ST_INIT;
						rcm_pkg::OP_SNAPSHOT, rcm_pkg::OP_HISTORY,
						rcm_pkg::OP_OVERFLOW: state_d = rcm_pkg::ST_SWEEP_RD;
						default: state_d = step_ok ? rcm_pkg::ST_READ : rcm_pkg::ST_DONE;
					endcase
				end
			end
			rcm_pkg::ST_READ: state_d = rcm_pkg::ST_EXEC;
			rcm_pkg::ST_EXEC: begin
				unique case (op_q)
					rcm_pkg::OP_ADD: begin
						nxt = (cur == '1) ? cur : cur + 1'b1;
						state_d = rcm_pkg::ST_DONE;
					end
					rcm_pkg::OP_REMOVE: begin
						nxt = (cur == '0) ? cur : cur - 1'b1;
						state_d = rcm_pkg::ST_DONE;
					end
					rcm_pkg::OP_COST: begin
						state_d = rcm_pkg::ST_DIV;
					end
					default: state_d = rcm_pkg::ST_DONE;
				endcase
				h_wuse = nxt;
				v_wuse = nxt;
				h_we = horiz_q && (op_q == rcm_pkg::OP_ADD || op_q == rcm_pkg::OP_REMOVE);
				v_we = !horiz_q && (op_q == rcm_pkg::OP_ADD || op_q == rcm_pkg::OP_REMOVE);
			end
			rcm_pkg::ST_DIV: begin
				if (cap_sel == '0) begin
					state_d = rcm_pkg::ST_COST;
				end else if (!div_ctl.busy && !div_ctl.done) begin
					div_start = 1'b1;
				end else if (div_ctl.done) begin
					state_d = rcm_pkg::ST_COST;
				end
			end
			rcm_pkg::ST_COST: state_d = rcm_pkg::ST_DONE;
			rcm_pkg::ST_SWEEP_RD: state_d = rcm_pkg::ST_SWEEP_WAIT;
			rcm_pkg::ST_SWEEP_WAIT: state_d = rcm_pkg::ST_SWEEP_WR;
			rcm_pkg::ST_SWEEP_WR: begin
				if (op_q == rcm_pkg::OP_SNAPSHOT) begin
					h_we = 1'b1;
					v_we = 1'b1;
					h_wmark = hin && h_use > hcap_q;
					v_wmark = vin && v_use > vcap_q;
				end else if (op_q == rcm_pkg::OP_HISTORY) begin
					h_we = 1'b1;
					v_we = 1'b1;
					if (hin && h_mark && h_hist != '1) h_whist = h_hist + 1'b1;
					if (vin && v_mark && v_hist != '1) v_whist = v_hist + 1'b1;
				end
				state_d = last_addr ? rcm_pkg::ST_DONE : rcm_pkg::ST_SWEEP_RD;
			end
			rcm_pkg::ST_DONE: if (!out_stall) state_d = rcm_pkg::ST_IDLE;
			default: state_d = rcm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rcm_pkg::ST_INIT;
		else state_q <= state_d;
	end

	// address counter and sweep coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			clear_q <= 1'b0;
		end else if (state_q == rcm_pkg::ST_IDLE && in_valid) begin
			clear_q <= operation == rcm_pkg::OP_CLEAR;
			if (operation == rcm_pkg::OP_CLEAR || operation == rcm_pkg::OP_SNAPSHOT
					|| operation == rcm_pkg::OP_HISTORY
					|| operation == rcm_pkg::OP_OVERFLOW) begin
				addr_q <= '0;
				ax_q <= '0;
				ay_q <= '0;
			end else begin
				addr_q <= AW'(sy) * AW'(MAX_COLUMNS) + AW'(sx);
			end
		end else if (state_q == rcm_pkg::ST_INIT
				|| state_q == rcm_pkg::ST_SWEEP_WR) begin
			if (!last_addr) begin
				addr_q <= addr_q + 1'b1;
				if (ax_q == XW'(MAX_COLUMNS - 1)) begin
					ax_q <= '0;
					ay_q <= ay_q + 1'b1;
				end else begin
					ax_q <= ax_q + 1'b1;
				end
			end
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		if (state_q == rcm_pkg::ST_IDLE && in_valid) begin
			op_q <= rcm_pkg::op_t'(operation);
			horiz_q <= step_h;
			cost_q <= '0;
			mark_q <= 1'b0;
			sum_q <= '0;
			bad_q <= !step_ok && (operation == rcm_pkg::OP_ADD
				|| operation == rcm_pkg::OP_REMOVE || operation == rcm_pkg::OP_COST
				|| operation == rcm_pkg::OP_QUERY);
		end
		if (state_q == rcm_pkg::ST_EXEC) begin
			num_q <= NUM_W'(cwt_q) * NUM_W'({1'b0, horiz_q ? h_use : v_use} + 9'd1);
			hprod_q <= 40'(32'(hwt_q) * 32'(horiz_q ? h_hist : v_hist));
			if (op_q == rcm_pkg::OP_QUERY) mark_q <= horiz_q ? h_mark : v_mark;
		end
		if (state_q == rcm_pkg::ST_COST) begin
			cost_q <= 40'd256 + hprod_q + ((cap_sel == '0)
				? 40'(num_q) * 40'(rcm_pkg::ZERO_CAP_SCALE) : 40'(div_quo));
		end
		if (state_q == rcm_pkg::ST_SWEEP_WR && op_q == rcm_pkg::OP_OVERFLOW) begin
			logic [22:0] acc;
			acc = 23'(sum_q)
				+ ((hin && h_use > hcap_q) ? 23'(h_use - hcap_q) : 23'd0)
				+ ((vin && v_use > vcap_q) ? 23'(v_use - vcap_q) : 23'd0);
			sum_q <= (acc > 23'(rcm_pkg::SUM_MAX)) ? rcm_pkg::SUM_MAX : acc[20:0];
		end
	end

	assign in_stall     = state_q != rcm_pkg::ST_IDLE;
	assign out_valid    = state_q == rcm_pkg::ST_DONE;
	assign step_cost    = cost_q;
	assign edge_marked  = mark_q;
	assign overflow_sum = sum_q;
	assign bad_step     = bad_q;

	// no input taken while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input accepted with pending result");

	// sweep visits addresses in order
	a_sweep_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rcm_pkg::ST_SWEEP_WR && !last_addr) |=> addr_q == $past(addr_q) + 1'b1)
		else $error("sweep address skipped");

	// bad step reports nothing else
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_step) |-> (step_cost == '0 && !edge_marked && overflow_sum == '0))
		else $error("bad step carries data");

endmodule

// ----- hw/rtl/rcm_divider.sv -----
module rcm_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rcm_pkg::NUM_W-1:0]     dividend,
	input  logic [rcm_pkg::CAP_W-1:0]     divisor,
	output rcm_pkg::div_ctl_t             ctl,
	output logic [rcm_pkg::NUM_W-1:0]     quotient
);

	localparam int unsigned CNT_W = $clog2(rcm_pkg::NUM_W + 1);

	logic [rcm_pkg::NUM_W-1:0] quo_q;
	logic [rcm_pkg::CAP_W:0]   rem_q;
	logic [rcm_pkg::CAP_W-1:0] dsr_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [rcm_pkg::CAP_W:0]   trial;
	logic                      fits;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q[rcm_pkg::CAP_W-1:0], quo_q[rcm_pkg::NUM_W-1]};
		fits  = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(rcm_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, dsr_q} : trial;
			quo_q <= {quo_q[rcm_pkg::NUM_W-2:0], fits};
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign quotient  = quo_q;

endmodule

// ----- hw/rtl/rcm_edge_store.sv -----
module rcm_edge_store #(
	parameter int unsigned DEPTH = 4096
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(DEPTH)-1:0]        waddr,
	input  logic [rcm_pkg::USE_W-1:0]       wuse,
	input  logic [rcm_pkg::HIST_W-1:0]      whist,
	input  logic                            wmark,
	input  logic [$clog2(DEPTH)-1:0]        raddr,
	output logic [rcm_pkg::USE_W-1:0]       ruse,
	output logic [rcm_pkg::HIST_W-1:0]      rhist,
	output logic                            rmark
);

	localparam int unsigned ENT_W = rcm_pkg::USE_W + rcm_pkg::HIST_W + 1;

	logic [ENT_W-1:0] mem [DEPTH];
	logic [ENT_W-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wuse, whist, wmark};
		end
		rdata_q <= mem[raddr];
	end

	assign {ruse, rhist, rmark} = rdata_q;

endmodule
